@@ rtl/core/ilc_pkg.sv @@
package ilc_pkg;

   // number base codes
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_HEX = 2'd2;

   // size codes
   localparam logic [2:0] SZ_INT8   = 3'd0;
   localparam logic [2:0] SZ_INT16  = 3'd1;
   localparam logic [2:0] SZ_UINT16 = 3'd2;
   localparam logic [2:0] SZ_INT32  = 3'd3;
   localparam logic [2:0] SZ_UINT32 = 3'd4;

   localparam logic [31:0] HIGH_BYTE_MASK = 32'h0000_ff00;

   // characters the prefix and suffix logic looks for
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
   localparam logic [7:0] CHAR_ELL   = 8'h6c;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   localparam logic [1:0] POS_LAST = 2'd2;

   typedef struct packed {
      logic [1:0]  base;
      logic [31:0] acc;
      logic        bad;
      logic [1:0]  pos;
   } tok_state_type;

   localparam tok_state_type TOK_CLEAR = '{
      base: BASE_DEC, acc: 32'd0, bad: 1'b0, pos: 2'd0
   };

endpackage

@@ rtl/core/ilc_step.sv @@
module ilc_step (
   input  ilc_pkg::tok_state_type cur_state,
   input  logic [7:0]             ch,
   input  logic                   first,
   input  logic                   last,
   output ilc_pkg::tok_state_type upd_state,
   output logic                   ell_flag
);

   ilc_pkg::tok_state_type start;
   logic [7:0]  lower;
   logic [5:0]  digit;
   logic        is_digit;
   logic [4:0]  radix;
   logic [31:0] scaled;
   logic [31:0] sum;

   always_comb begin
      start = first ? ilc_pkg::TOK_CLEAR : cur_state;

      lower = (ch >= ilc_pkg::CHAR_UP_A && ch <= ilc_pkg::CHAR_UP_Z) ?
              ch + ilc_pkg::CASE_SHIFT : ch;
      ell_flag = (lower == ilc_pkg::CHAR_ELL);

      // digit value; letters run 10..35
      is_digit = 1'b1;
      digit    = 6'd0;
      if (ch >= ilc_pkg::CHAR_ZERO && ch <= ilc_pkg::CHAR_NINE) begin
         digit = 6'(ch - ilc_pkg::CHAR_ZERO);
      end else if (lower >= ilc_pkg::CHAR_LO_A && lower <= ilc_pkg::CHAR_LO_Z) begin
         digit = 6'(lower - ilc_pkg::CHAR_LO_A) + 6'd10;
      end else begin
         is_digit = 1'b0;
      end

      // shift-and-add multiply by the base
      case (start.base)
         ilc_pkg::BASE_OCT: begin
            radix  = 5'd8;
            scaled = {start.acc[28:0], 3'b000};
         end
         ilc_pkg::BASE_HEX: begin
            radix  = 5'd16;
            scaled = {start.acc[27:0], 4'b0000};
         end
         default: begin
            radix  = 5'd10;
            scaled = {start.acc[28:0], 3'b000} + {start.acc[30:0], 1'b0};
         end
      endcase
      sum = scaled + {26'd0, digit};

      upd_state = start;
      if (last && ell_flag) begin
         // suffix, no effect on value or legality
      end else if (start.pos == 2'd0 && ch == ilc_pkg::CHAR_ZERO) begin
         upd_state.base = ilc_pkg::BASE_OCT;
      end else if (start.pos == 2'd1 && start.base == ilc_pkg::BASE_OCT &&
                   lower == ilc_pkg::CHAR_X) begin
         upd_state.base = ilc_pkg::BASE_HEX;
      end else if (!is_digit || {1'b0, digit} >= {2'b00, radix}) begin
         upd_state.bad = 1'b1;
      end else if (!start.bad) begin
         upd_state.acc = sum;
      end

      if (start.pos != ilc_pkg::POS_LAST) begin
         upd_state.pos = start.pos + 2'd1;
      end
   end

endmodule

@@ rtl/core/ilc_size_classify.sv @@
module ilc_size_classify (
   input  logic [31:0] value,
   input  logic [1:0]  base,
   input  logic        ell,
   output logic [2:0]  size_code
);

   logic dec;
   logic big;
   logic mid;

   always_comb begin
      dec = !(base == ilc_pkg::BASE_OCT || base == ilc_pkg::BASE_HEX);
      big = ell ||
            (dec && value[31:16] != {16{value[15]}}) ||
            (!dec && value[31:16] != 16'd0);
      mid = (dec && value[15:8] != {8{value[7]}}) ||
            (!dec && (value & ilc_pkg::HIGH_BYTE_MASK) != 32'd0);

      if (big) begin
         size_code = (dec || !value[31]) ? ilc_pkg::SZ_INT32 : ilc_pkg::SZ_UINT32;
      end else if (mid) begin
         size_code = (!dec || !value[15]) ? ilc_pkg::SZ_INT16 : ilc_pkg::SZ_UINT16;
      end else begin
         size_code = (!dec || !value[7]) ? ilc_pkg::SZ_INT8 : ilc_pkg::SZ_INT16;
      end
   end

endmodule

@@ rtl/core/integer_literal_classifier.sv @@
// integer literal classifier: takes one character word per cycle (req_ch with
// req_first / req_last marks) unless a last character waits for the output
// slot, and, on the last character, returns one result word with the value
// modulo 2^32, the size code and the illegal flag. words carrying no last mark
// give no result. a word is registered on accept in the input register, is
// processed from there by the digit step and size logic, and the result lands
// in the output register, which drives rsp_valid. throughput is one character
// per cycle while no last character stalls, held by the combinational
// accumulator update (shift-and-add by 8, 10 or 16); a result waiting in the
// output register does not block characters that are not last
module integer_literal_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_size_code,
   output logic        rsp_illegal
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_first_ff;
   logic       in_last_ff;

   // token state
   ilc_pkg::tok_state_type tok_ff, tok_in;
   ilc_pkg::tok_state_type upd_state;
   logic                   ell_flag;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff;
   logic [2:0]  out_size_ff;
   logic        out_illegal_ff;
   logic [2:0]  size_code;

   logic out_free;
   logic proc_fire;
   logic req_fire;

   // output slot is free if empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // a last character needs the output slot, others go straight through
   assign proc_fire = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   ilc_step u_step (
      .cur_state (tok_ff),
      .ch        (in_ch_ff),
      .first     (in_first_ff),
      .last      (in_last_ff),
      .upd_state (upd_state),
      .ell_flag  (ell_flag)
   );

   ilc_size_classify u_size (
      .value     (upd_state.acc),
      .base      (upd_state.base),
      .ell       (ell_flag),
      .size_code (size_code)
   );

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_ff);

      // token state restarts after every result
      tok_in = tok_ff;
      if (proc_fire) begin
         tok_in = in_last_ff ? ilc_pkg::TOK_CLEAR : upd_state;
      end

      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (proc_fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tok_ff       <= ilc_pkg::TOK_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         tok_ff       <= tok_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ch_ff    <= req_ch;
         in_first_ff <= req_first;
         in_last_ff  <= req_last;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (proc_fire && in_last_ff) begin
         out_value_ff   <= upd_state.acc;
         out_size_ff    <= size_code;
         out_illegal_ff <= upd_state.bad;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_size_code = out_size_ff;
   assign rsp_illegal   = out_illegal_ff;

endmodule

@@ tb/integer_literal_classifier_tb.sv @@
`timescale 1ns / 1ps

module integer_literal_classifier_tb;

   localparam int CLOCK_HALF      = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_CHARS    = 1850;
   // margin after the last result, which leaves through the input and output registers
   localparam int DRAIN_CYCLES    = 8;
   // far beyond the slowest run: every word waiting out the longest gap and stall
   localparam longint TIMEOUT_NS  = 64'd20_000_000;

   localparam logic [31:0] RADIX_OCT = 32'd8;
   localparam logic [31:0] RADIX_DEC = 32'd10;
   localparam logic [31:0] RADIX_HEX = 32'd16;
   localparam logic [7:0]  NO_DIGIT  = 8'hff;

   // how the first mark is placed on a token
   typedef enum {FIRST_NORMAL, FIRST_MISSING, FIRST_EXTRA} first_mark_mode_type;

   // one classified literal as it should leave the block
   typedef struct {
      logic [31:0] value;
      logic [2:0]  size_code;
      logic        illegal;
   } literal_result_type;

   // dut ports, inputs driven to known values from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        req_first = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_value;
   logic [2:0]  rsp_size_code;
   logic        rsp_illegal;

   // token state of the predictor
   logic [1:0]  tok_base = ilc_pkg::BASE_DEC;
   logic [31:0] tok_acc = 32'd0;
   logic        tok_bad = 1'b0;
   logic [1:0]  tok_pos = 2'd0;
   logic        tok_ell = 1'b0;

   literal_result_type expected_literals[$];
   logic [7:0]         token_buf[$];

   int  fail_count = 0;
   int  chars_sent = 0;
   // when low, neither side idles
   bit  gaps_on = 1'b1;
   int  rsp_stall_left = 0;

   integer_literal_classifier uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_first     (req_first),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_size_code (rsp_size_code),
      .rsp_illegal   (rsp_illegal)
   );

   always #CLOCK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function automatic void clear_token_state();
      tok_base = ilc_pkg::BASE_DEC;
      tok_acc  = 32'd0;
      tok_bad  = 1'b0;
      tok_pos  = 2'd0;
      tok_ell  = 1'b0;
   endfunction

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= ilc_pkg::CHAR_UP_A && c <= ilc_pkg::CHAR_UP_Z) ?
             c + ilc_pkg::CASE_SHIFT : c;
   endfunction

   // digit value of a character, letters continue after nine
   function automatic logic [7:0] digit_of(logic [7:0] c);
      logic [7:0] low_c;
      low_c = fold_case(c);
      if (c >= ilc_pkg::CHAR_ZERO && c <= ilc_pkg::CHAR_NINE) return c - ilc_pkg::CHAR_ZERO;
      if (low_c >= ilc_pkg::CHAR_LO_A && low_c <= ilc_pkg::CHAR_LO_Z)
         return low_c - ilc_pkg::CHAR_LO_A + 8'd10;
      return NO_DIGIT;
   endfunction

   // unused base code falls back to decimal
   function automatic logic [31:0] radix_for(logic [1:0] b);
      case (b)
         ilc_pkg::BASE_OCT: return RADIX_OCT;
         ilc_pkg::BASE_HEX: return RADIX_HEX;
         default:           return RADIX_DEC;
      endcase
   endfunction

   // decimal sizes by signed fit, octal and hex by which bytes are populated
   function automatic logic [2:0] size_for(logic [31:0] v, logic dec, logic ell);
      logic [31:0] sx16;
      logic [31:0] sx8;
      logic        wide;
      logic        mid;
      sx16 = {{16{v[15]}}, v[15:0]};
      sx8  = {{24{v[7]}}, v[7:0]};
      wide = ell || (dec ? (sx16 != v) : (v[31:16] != 16'd0));
      mid  = dec ? (sx8 != sx16) : ((v & ilc_pkg::HIGH_BYTE_MASK) != 32'd0);
      if (wide) return (dec || !v[31]) ? ilc_pkg::SZ_INT32 : ilc_pkg::SZ_UINT32;
      if (mid) return (!dec || !v[15]) ? ilc_pkg::SZ_INT16 : ilc_pkg::SZ_UINT16;
      return (!dec || !v[7]) ? ilc_pkg::SZ_INT8 : ilc_pkg::SZ_INT16;
   endfunction

   // one accepted character word: advance the token, queue a result on last
   function automatic void classify_char(logic [7:0] c, logic first, logic last);
      logic [7:0]         low_c;
      logic [7:0]         digit;
      logic [31:0]        radix;
      logic               is_ell;
      literal_result_type res;
      low_c  = fold_case(c);
      is_ell = (low_c == ilc_pkg::CHAR_ELL);
      if (first) clear_token_state();
      // a final ell is a suffix and leaves the digits alone
      if (!(last && is_ell)) begin
         if (tok_pos == 2'd0 && c == ilc_pkg::CHAR_ZERO) begin
            tok_base = ilc_pkg::BASE_OCT;
         end else if (tok_pos == 2'd1 && tok_base == ilc_pkg::BASE_OCT &&
                      low_c == ilc_pkg::CHAR_X) begin
            tok_base = ilc_pkg::BASE_HEX;
         end else begin
            radix = radix_for(tok_base);
            digit = digit_of(c);
            if (digit >= radix) begin
               tok_bad = 1'b1;
            end else if (!tok_bad) begin
               tok_acc = tok_acc * radix + digit;
            end
         end
      end
      tok_ell = is_ell;
      if (tok_pos < ilc_pkg::POS_LAST) tok_pos = tok_pos + 2'd1;
      if (last) begin
         res.value     = tok_acc;
         res.size_code = size_for(tok_acc, radix_for(tok_base) == RADIX_DEC, tok_ell);
         res.illegal   = tok_bad;
         expected_literals.push_back(res);
         clear_token_state();
      end
   endfunction

   // ---------------------------------------------------------------------
   // monitors, both sample the values from just before the edge
   // ---------------------------------------------------------------------

   // every accepted character word feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) classify_char(req_ch, req_first, req_last);
   end

   // every accepted result word is matched against the oldest expectation
   always @(posedge clock) begin : check_results
      literal_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_literals.size() == 0) begin
            $error("unexpected result word: value %h size_code %0d illegal %b",
                   rsp_value, rsp_size_code, rsp_illegal);
            fail_count++;
         end else begin
            want = expected_literals.pop_front();
            if (rsp_value !== want.value) begin
               $error("value: expected %h, actual %h", want.value, rsp_value);
               fail_count++;
            end
            if (rsp_size_code !== want.size_code) begin
               $error("size_code: expected %0d, actual %0d", want.size_code, rsp_size_code);
               fail_count++;
            end
            if (rsp_illegal !== want.illegal) begin
               $error("illegal: expected %b, actual %b", want.illegal, rsp_illegal);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // idling on both sides
   // ---------------------------------------------------------------------

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver stalls
   always @(posedge clock) begin : drive_rsp_ready
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         stall = pick_idle_length();
         rsp_ready <= (stall == 0);
         if (stall > 0) rsp_stall_left = stall - 1;
      end
   end

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------

   // one character word, preceded by a random gap, held until accepted
   task automatic send_char(input logic [7:0] c, input logic first, input logic last);
      int gap;
      gap = pick_idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_first <= first;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   // sends token_buf as one token, last mark on its final character
   task automatic send_token(input first_mark_mode_type mode);
      int extra_at;
      logic first;
      extra_at = (token_buf.size() > 1) ? $urandom_range(1, token_buf.size() - 1) : 0;
      for (int i = 0; i < token_buf.size(); i++) begin
         first = (i == 0 && mode != FIRST_MISSING) || (mode == FIRST_EXTRA && i == extra_at);
         send_char(token_buf[i], first, i == token_buf.size() - 1);
      end
      token_buf.delete();
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
   endtask

   // sender holds off until every expected result word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_literals.size() != 0) @(posedge clock);
   endtask

   // well-formed literal of random base, length and suffix
   task automatic build_literal();
      int base_pick;
      int ndig;
      int v;
      logic [7:0] c;
      base_pick = $urandom_range(0, 2);
      ndig = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 4) : $urandom_range(5, 12);
      if (base_pick == 0) begin
         // decimal must not start with zero
         c = ilc_pkg::CHAR_ZERO + 8'($urandom_range(1, 9));
         token_buf.push_back(c);
      end else begin
         token_buf.push_back(ilc_pkg::CHAR_ZERO);
         if (base_pick == 2) begin
            c = $urandom_range(0, 1) ? ilc_pkg::CHAR_X : ilc_pkg::CHAR_X - ilc_pkg::CASE_SHIFT;
            token_buf.push_back(c);
         end
      end
      for (int i = 0; i < ndig; i++) begin
         if (base_pick == 0) begin
            c = ilc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         end else if (base_pick == 1) begin
            c = ilc_pkg::CHAR_ZERO + 8'($urandom_range(0, 7));
         end else begin
            v = $urandom_range(0, 15);
            if (v < 10) c = ilc_pkg::CHAR_ZERO + 8'(v);
            else c = ($urandom_range(0, 1) ? ilc_pkg::CHAR_UP_A : ilc_pkg::CHAR_LO_A) +
                     8'(v - 10);
         end
         token_buf.push_back(c);
      end
      if ($urandom_range(0, 3) == 0) begin
         c = $urandom_range(0, 1) ? ilc_pkg::CHAR_ELL :
             ilc_pkg::CHAR_ELL - ilc_pkg::CASE_SHIFT;
         token_buf.push_back(c);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // bare prefixes and suffix-only tokens
   task automatic test_prefixes();
      load_text("0");
      send_token(FIRST_NORMAL);
      load_text("0X");
      send_token(FIRST_NORMAL);
      load_text("L");
      send_token(FIRST_NORMAL);
      load_text("0xl");
      send_token(FIRST_NORMAL);
   endtask

   // largest hex value, mixed case digits
   task automatic test_extremes();
      load_text("0xFfFfFfFf");
      send_token(FIRST_NORMAL);
   endtask

   task automatic test_special_cases();
      // ell in the middle, then a non-ascii character
      load_text("1l");
      token_buf.push_back(8'hff);
      send_token(FIRST_NORMAL);
      // digit out of range for octal
      load_text("08");
      send_token(FIRST_NORMAL);
      // no first mark after a result
      send_char(ilc_pkg::CHAR_ZERO + 8'd7, 1'b0, 1'b1);
      // first mark again in the middle of a token
      send_char(ilc_pkg::CHAR_ZERO + 8'd5, 1'b1, 1'b0);
      send_char(ilc_pkg::CHAR_ZERO + 8'd3, 1'b1, 1'b1);
   endtask

   // mostly well-formed literals, some corrupted, some raw noise
   task automatic test_random_traffic();
      int target;
      int next_toggle;
      int kind;
      int n;
      bit drained_mid;
      logic [7:0] c;
      logic fm;
      logic lm;
      target      = chars_sent + RANDOM_CHARS;
      next_toggle = chars_sent + 150;
      drained_mid = 1'b0;
      while (chars_sent < target) begin
         // alternate stretches with and without idling
         if (chars_sent >= next_toggle) begin
            gaps_on     = ($urandom_range(0, 9) < 7);
            next_toggle = chars_sent + $urandom_range(100, 250);
         end
         if (!drained_mid && chars_sent >= target - RANDOM_CHARS / 2) begin
            wait_drained();
            drained_mid = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            build_literal();
            send_token(FIRST_NORMAL);
         end else if (kind < 85) begin
            build_literal();
            c = 8'($urandom_range(0, 255));
            token_buf[$urandom_range(0, token_buf.size() - 1)] = c;
            n = $urandom_range(0, 2);
            if (n == 0) send_token(FIRST_NORMAL);
            else if (n == 1) send_token(FIRST_MISSING);
            else send_token(FIRST_EXTRA);
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               c  = 8'($urandom_range(0, 255));
               fm = 1'($urandom_range(0, 1));
               lm = 1'($urandom_range(0, 1));
               send_char(c, fm, lm);
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_prefixes();
      test_extremes();
      test_special_cases();
      wait_drained();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
